### hdl/i2cee_pkg.sv
`default_nettype none

package i2cee_pkg;

   // Command codes of the request word.
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_RETRY_LIMIT    = 1'b1;

   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd160;
   localparam logic [7:0] RETRY_LIMIT_RESET    = 8'd3;

   // One result word.
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic       success;
      logic [7:0] read_byte;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/i2c_eeprom_byte_access_unit.sv
`default_nettype none

// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/stall    | cmd, mem_address, write_byte, sda_in
// rsp     | out       | rsp_valid/stall    | scl/sda levels, sda_drive, busy, done,
//         |           |                    | success, read_byte
// csr     | in        | csr_write_en       | csr_index, csr_write_data
//
// One word is accepted every cycle while req_stall is low; its result appears in the
// output register on the next cycle. The sequencer state advances by one pin phase per accepted tick word.
// Synchronous reset returns the sequencer to idle with SCL low and SDA driven high.
// A stalled result holds the output register, and req_stall rises only while a
// result waits and the result side stalls.
module i2c_eeprom_byte_access_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_cmd,
   input  wire  [15:0] req_mem_address,
   input  wire  [7:0]  req_write_byte,
   input  wire         req_sda_in,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_sda_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_success,
   output logic [7:0]  rsp_read_byte,
   input  wire         csr_write_en,
   input  wire         csr_index,
   input  wire  [7:0]  csr_write_data
);

   i2cee_pkg::rsp_type result;
   i2cee_pkg::rsp_type rsp_word;
   logic               can_load;
   logic               take;

   assign req_stall = !can_load;
   assign take      = req_valid && can_load;

   i2cee_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .cmd            (req_cmd),
      .mem_address    (req_mem_address),
      .write_byte     (req_write_byte),
      .sda_in         (req_sda_in),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .result         (result)
   );

   i2cee_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .result    (result),
      .rsp_stall (rsp_stall),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_scl_level = rsp_word.scl_level;
   assign rsp_sda_level = rsp_word.sda_level;
   assign rsp_sda_drive = rsp_word.sda_drive;
   assign rsp_busy_res  = rsp_word.busy_res;
   assign rsp_done_res  = rsp_word.done_res;
   assign rsp_success   = rsp_word.success;
   assign rsp_read_byte = rsp_word.read_byte;

endmodule

`default_nettype wire

### hdl/i2cee_seq.sv
`default_nettype none

module i2cee_seq (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  take,
   input  wire [1:0]            cmd,
   input  wire [15:0]           mem_address,
   input  wire [7:0]            write_byte,
   input  wire                  sda_in,
   input  wire                  csr_write_en,
   input  wire                  csr_index,
   input  wire [7:0]            csr_write_data,
   output i2cee_pkg::rsp_type   result
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3,
      PH_WPRE, PH_WSDA, PH_WHI, PH_WLO, PH_AHI, PH_ASMP,
      PH_RHI, PH_RSMP, PH_NK0, PH_NK1, PH_NK2,
      PH_SP0, PH_SP1, PH_SP2, PH_SP3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  tries_ff, tries_in;
   logic [15:0] address_ff, address_in;
   logic [7:0]  data_ff, data_in;
   logic        is_read_ff, is_read_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_lvl_in;
   logic        drive_ff, drive_in;
   logic [7:0]  dev_addr_ff;
   logic [7:0]  retry_ff;

   logic [3:0]  bit_count_inc;
   logic [2:0]  byte_index_inc;
   logic [7:0]  tries_dec;
   logic        done, ok;
   logic [7:0]  rd;

   // Byte sent in the frame at a given position.
   function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [7:0] dev,
                                             input logic [15:0] adr, input logic [7:0] dat,
                                             input logic rd_op);
      logic [7:0] b;
      case (idx)
         3'd0:    b = dev & 8'hfe;
         3'd1:    b = adr[15:8];
         3'd2:    b = adr[7:0];
         default: b = rd_op ? (dev | 8'h01) : dat;
      endcase
      return b;
   endfunction

   assign bit_count_inc  = bit_count_ff + 4'd1;
   assign byte_index_inc = byte_index_ff + 3'd1;
   assign tries_dec      = tries_ff - 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      byte_index_in = byte_index_ff;
      shift_in      = shift_ff;
      tries_in      = tries_ff;
      address_in    = address_ff;
      data_in       = data_ff;
      is_read_in    = is_read_ff;
      scl_in        = scl_ff;
      sda_lvl_in    = sda_ff;
      drive_in      = drive_ff;
      done          = 1'b0;
      ok            = 1'b0;
      rd            = 8'd0;
      if (phase_ff == PH_IDLE) begin
         if (cmd == i2cee_pkg::CMD_WRITE || cmd == i2cee_pkg::CMD_READ) begin
            address_in    = mem_address;
            data_in       = write_byte;
            is_read_in    = (cmd == i2cee_pkg::CMD_READ);
            tries_in      = retry_ff;
            byte_index_in = 3'd0;
            bit_count_in  = 4'd0;
            if (retry_ff == 8'd0) begin
               done = 1'b1;
            end else begin
               phase_in = PH_ST0;
            end
         end
      end else if (cmd == i2cee_pkg::CMD_TICK) begin
         case (phase_ff)
            PH_ST0: begin drive_in = 1'b1; sda_lvl_in = 1'b1; phase_in = PH_ST1; end
            PH_ST1: begin scl_in = 1'b1; phase_in = PH_ST2; end
            PH_ST2: begin sda_lvl_in = 1'b0; phase_in = PH_ST3; end
            PH_ST3: begin
               scl_in       = 1'b0;
               shift_in     = frame_byte(byte_index_ff, dev_addr_ff, address_ff, data_ff,
                                         is_read_ff);
               bit_count_in = 4'd0;
               phase_in     = PH_WPRE;
            end
            PH_WPRE: begin drive_in = 1'b1; scl_in = 1'b0; phase_in = PH_WSDA; end
            PH_WSDA: begin sda_lvl_in = shift_ff[7]; phase_in = PH_WHI; end
            PH_WHI:  begin scl_in = 1'b1; phase_in = PH_WLO; end
            PH_WLO: begin
               scl_in       = 1'b0;
               shift_in     = {shift_ff[6:0], 1'b0};
               bit_count_in = bit_count_inc;
               phase_in     = (bit_count_inc >= 4'd8) ? PH_AHI : PH_WSDA;
            end
            PH_AHI: begin drive_in = 1'b0; scl_in = 1'b1; phase_in = PH_ASMP; end
            PH_ASMP: begin
               scl_in = 1'b0;
               if (sda_in) begin
                  // Missing acknowledge: restart the frame or give up.
                  tries_in      = tries_dec;
                  byte_index_in = 3'd0;
                  if (tries_dec == 8'd0) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_ST0;
                  end
               end else begin
                  byte_index_in = byte_index_inc;
                  if (byte_index_inc <= 3'd2 || (!is_read_ff && byte_index_inc == 3'd3))
                     begin
                     shift_in     = frame_byte(byte_index_inc, dev_addr_ff, address_ff,
                                               data_ff, is_read_ff);
                     bit_count_in = 4'd0;
                     phase_in     = PH_WPRE;
                  end else if (!is_read_ff) begin
                     phase_in = PH_SP0;
                  end else if (byte_index_inc == 3'd3) begin
                     // Repeated start before the device address with the read bit.
                     phase_in = PH_ST0;
                  end else begin
                     shift_in     = 8'd0;
                     bit_count_in = 4'd0;
                     phase_in     = PH_RHI;
                  end
               end
            end
            PH_RHI: begin drive_in = 1'b0; scl_in = 1'b1; phase_in = PH_RSMP; end
            PH_RSMP: begin
               scl_in       = 1'b0;
               shift_in     = {shift_ff[6:0], sda_in};
               bit_count_in = bit_count_inc;
               phase_in     = (bit_count_inc >= 4'd8) ? PH_NK0 : PH_RHI;
            end
            PH_NK0: begin drive_in = 1'b1; sda_lvl_in = 1'b1; phase_in = PH_NK1; end
            PH_NK1: begin scl_in = 1'b1; phase_in = PH_NK2; end
            PH_NK2: begin scl_in = 1'b0; phase_in = PH_SP0; end
            PH_SP0: begin drive_in = 1'b1; sda_lvl_in = 1'b0; phase_in = PH_SP1; end
            PH_SP1: begin scl_in = 1'b1; phase_in = PH_SP2; end
            PH_SP2: begin sda_lvl_in = 1'b1; phase_in = PH_SP3; end
            PH_SP3: begin
               scl_in   = 1'b0;
               done     = 1'b1;
               ok       = 1'b1;
               rd       = is_read_ff ? shift_ff : 8'd0;
               phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_comb begin
      result.scl_level = scl_in;
      result.sda_level = sda_lvl_in;
      result.sda_drive = drive_in;
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.success   = ok;
      result.read_byte = rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 4'd0;
         byte_index_ff <= 3'd0;
         shift_ff      <= 8'd0;
         tries_ff      <= 8'd0;
         address_ff    <= 16'd0;
         data_ff       <= 8'd0;
         is_read_ff    <= 1'b0;
         scl_ff        <= 1'b0;
         sda_ff        <= 1'b1;
         drive_ff      <= 1'b1;
         dev_addr_ff   <= i2cee_pkg::DEVICE_ADDRESS_RESET;
         retry_ff      <= i2cee_pkg::RETRY_LIMIT_RESET;
      end else begin
         if (take) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            byte_index_ff <= byte_index_in;
            shift_ff      <= shift_in;
            tries_ff      <= tries_in;
            address_ff    <= address_in;
            data_ff       <= data_in;
            is_read_ff    <= is_read_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_lvl_in;
            drive_ff      <= drive_in;
         end
         if (csr_write_en) begin
            case (csr_index)
               i2cee_pkg::CSR_DEVICE_ADDRESS: dev_addr_ff <= csr_write_data;
               i2cee_pkg::CSR_RETRY_LIMIT:    retry_ff    <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

### hdl/i2cee_out.sv
`default_nettype none

module i2cee_out (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  i2cee_pkg::rsp_type   result,
   input  wire                  rsp_stall,
   output logic                 can_load,
   output logic                 rsp_valid,
   output i2cee_pkg::rsp_type   rsp_word
);

   logic               valid_ff, valid_in;
   i2cee_pkg::rsp_type word_ff;

   // A new word may enter when the register is empty or its word leaves now.
   assign can_load = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire

### bench/i2c_eeprom_byte_access_unit_test.sv
`timescale 1ns / 100ps

module i2c_eeprom_byte_access_unit_test;

   typedef enum logic [5:0] {
      S_IDLE, S_START_A, S_START_B, S_START_C, S_START_D,
      S_BIT_PREP, S_BIT_DATA, S_BIT_HIGH, S_BIT_LOW,
      S_ACK_HIGH, S_ACK_SAMPLE, S_RD_HIGH, S_RD_SAMPLE,
      S_NACK_A, S_NACK_B, S_NACK_C,
      S_STOP_A, S_STOP_B, S_STOP_C, S_STOP_D
   } seq_state_type;

   // Bus sequencer mirror: one pin phase per tick word, expected words kept in order.
   class eeprom_scoreboard;
      logic [7:0]          dev_addr;
      logic [7:0]          tries_max;
      seq_state_type       state;
      logic [3:0]          bits_done;
      logic [2:0]          byte_num;
      logic [7:0]          shifter;
      logic [7:0]          tries;
      logic [15:0]         addr_hold;
      logic [7:0]          data_hold;
      bit                  reading;
      logic                scl, sda, drive;
      i2cee_pkg::rsp_type  pending[$];
      int                  errors;

      function new();
         dev_addr = i2cee_pkg::DEVICE_ADDRESS_RESET;
         tries_max = i2cee_pkg::RETRY_LIMIT_RESET;
         state = S_IDLE;
         bits_done = '0;
         byte_num = '0;
         shifter = '0;
         tries = '0;
         addr_hold = '0;
         data_hold = '0;
         reading = 1'b0;
         scl = 1'b0;
         sda = 1'b1;
         drive = 1'b1;
         errors = 0;
      endfunction

      function void set_register(input logic idx, input logic [7:0] val);
         if (idx == i2cee_pkg::CSR_DEVICE_ADDRESS) dev_addr = val;
         else tries_max = val;
      endfunction

      // Byte order of a frame: device address (write), address high, address low,
      // then the data byte or the device address with the read bit.
      function void load_byte();
         case (byte_num)
            3'd0: shifter = dev_addr & 8'hfe;
            3'd1: shifter = addr_hold[15:8];
            3'd2: shifter = addr_hold[7:0];
            default: shifter = reading ? (dev_addr | 8'h01) : data_hold;
         endcase
         bits_done = '0;
         state = S_BIT_PREP;
      endfunction

      function void note_word(input logic [1:0] cmd, input logic [15:0] addr,
                              input logic [7:0] data, input logic sda_bit);
         i2cee_pkg::rsp_type want;
         want = '0;
         if (state == S_IDLE) begin
            if (cmd == i2cee_pkg::CMD_WRITE || cmd == i2cee_pkg::CMD_READ) begin
               addr_hold = addr;
               data_hold = data;
               reading = (cmd == i2cee_pkg::CMD_READ);
               tries = tries_max;
               byte_num = '0;
               bits_done = '0;
               if (tries == 8'd0) want.done_res = 1'b1;
               else state = S_START_A;
            end
         end else if (cmd == i2cee_pkg::CMD_TICK) begin
            case (state)
               S_START_A: begin drive = 1'b1; sda = 1'b1; state = S_START_B; end
               S_START_B: begin scl = 1'b1; state = S_START_C; end
               S_START_C: begin sda = 1'b0; state = S_START_D; end
               S_START_D: begin scl = 1'b0; load_byte(); end
               S_BIT_PREP: begin drive = 1'b1; scl = 1'b0; state = S_BIT_DATA; end
               S_BIT_DATA: begin sda = shifter[7]; state = S_BIT_HIGH; end
               S_BIT_HIGH: begin scl = 1'b1; state = S_BIT_LOW; end
               S_BIT_LOW: begin
                  scl = 1'b0;
                  shifter = shifter << 1;
                  bits_done = bits_done + 4'd1;
                  state = (bits_done >= 4'd8) ? S_ACK_HIGH : S_BIT_DATA;
               end
               S_ACK_HIGH: begin drive = 1'b0; scl = 1'b1; state = S_ACK_SAMPLE; end
               S_ACK_SAMPLE: begin
                  scl = 1'b0;
                  if (sda_bit) begin
                     // Refused byte: restart the whole frame without a stop.
                     tries = tries - 8'd1;
                     byte_num = '0;
                     if (tries == 8'd0) begin
                        state = S_IDLE;
                        want.done_res = 1'b1;
                     end else begin
                        state = S_START_A;
                     end
                  end else begin
                     byte_num = byte_num + 3'd1;
                     if (byte_num <= 3'd2) load_byte();
                     else if (!reading) begin
                        if (byte_num == 3'd3) load_byte();
                        else state = S_STOP_A;
                     end else if (byte_num == 3'd3) begin
                        state = S_START_A;
                     end else begin
                        shifter = '0;
                        bits_done = '0;
                        state = S_RD_HIGH;
                     end
                  end
               end
               S_RD_HIGH: begin drive = 1'b0; scl = 1'b1; state = S_RD_SAMPLE; end
               S_RD_SAMPLE: begin
                  scl = 1'b0;
                  shifter = {shifter[6:0], sda_bit};
                  bits_done = bits_done + 4'd1;
                  state = (bits_done >= 4'd8) ? S_NACK_A : S_RD_HIGH;
               end
               S_NACK_A: begin drive = 1'b1; sda = 1'b1; state = S_NACK_B; end
               S_NACK_B: begin scl = 1'b1; state = S_NACK_C; end
               S_NACK_C: begin scl = 1'b0; state = S_STOP_A; end
               S_STOP_A: begin drive = 1'b1; sda = 1'b0; state = S_STOP_B; end
               S_STOP_B: begin scl = 1'b1; state = S_STOP_C; end
               S_STOP_C: begin sda = 1'b1; state = S_STOP_D; end
               S_STOP_D: begin
                  scl = 1'b0;
                  want.done_res = 1'b1;
                  want.success = 1'b1;
                  want.read_byte = reading ? shifter : 8'h00;
                  state = S_IDLE;
               end
               default: state = S_IDLE;
            endcase
         end
         want.scl_level = scl;
         want.sda_level = sda;
         want.sda_drive = drive;
         want.busy_res = (state != S_IDLE);
         pending.push_back(want);
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(input i2cee_pkg::rsp_type got);
         i2cee_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
         compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
         compare_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
         compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
         compare_field("success", 8'(want.success), 8'(got.success));
         compare_field("read_byte", want.read_byte, got.read_byte);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [15:0] req_mem_address;
   logic [7:0]  req_write_byte;
   logic        req_sda_in;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_sda_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_success;
   logic [7:0]  rsp_read_byte;
   logic        csr_write_en;
   logic        csr_index;
   logic [7:0]  csr_write_data;

   eeprom_scoreboard sb = new();
   bit          no_gaps = 1'b0;
   bit          hold_off_req = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_left = 0;
   int          nack_pct = 10;
   int          steps_taken = 0;

   i2c_eeprom_byte_access_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_mem_address (req_mem_address),
      .req_write_byte  (req_write_byte),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_sda_drive   (rsp_sda_drive),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_success     (rsp_success),
      .rsp_read_byte   (rsp_read_byte),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always #5 clock = ~clock;

   // Result side: check accepted words and stall at random, with one long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word({rsp_scl_level, rsp_sda_level, rsp_sda_drive, rsp_busy_res,
                        rsp_done_res, rsp_success, rsp_read_byte});
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_off_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 150;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_gaps && ($urandom_range(99) < 16);
      end
   end

   // Offers one word and returns right after the edge that took it.
   task automatic send_word(input logic [1:0] cmd, input logic [15:0] addr,
                            input logic [7:0] data, input logic sda_bit);
      if (!no_gaps) begin
         while ($urandom_range(99) < 16) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_mem_address <= addr;
      req_write_byte <= data;
      req_sda_in <= sda_bit;
      do @(posedge clock); while (!(req_valid && !req_stall));
      if ((sb.state == S_IDLE) ?
          (cmd == i2cee_pkg::CMD_WRITE || cmd == i2cee_pkg::CMD_READ) :
          (cmd == i2cee_pkg::CMD_TICK))
         steps_taken++;
      sb.note_word(cmd, addr, data, sda_bit);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] dev, input logic [7:0] limit);
      csr_write_en <= 1'b1;
      csr_index <= i2cee_pkg::CSR_DEVICE_ADDRESS;
      csr_write_data <= dev;
      @(posedge clock);
      sb.set_register(i2cee_pkg::CSR_DEVICE_ADDRESS, dev);
      csr_index <= i2cee_pkg::CSR_RETRY_LIMIT;
      csr_write_data <= limit;
      @(posedge clock);
      sb.set_register(i2cee_pkg::CSR_RETRY_LIMIT, limit);
      csr_write_en <= 1'b0;
   endtask

   // One request and the tick words that carry it to its end. The acknowledge is
   // refused now and then, and read bits come back at random.
   task automatic run_transfer();
      logic [1:0] kind;
      logic       sda_bit;
      kind = $urandom_range(1) ? i2cee_pkg::CMD_READ : i2cee_pkg::CMD_WRITE;
      if ($urandom_range(9) == 0)
         send_word($urandom_range(1) ? i2cee_pkg::CMD_UNUSED : i2cee_pkg::CMD_TICK,
                   16'($urandom), 8'($urandom), 1'($urandom_range(1)));
      send_word(kind, 16'($urandom), 8'($urandom), 1'($urandom_range(1)));
      while (sb.state != S_IDLE) begin
         if ($urandom_range(99) < 4) begin
            send_word(2'($urandom_range(3, 1)), 16'($urandom), 8'($urandom),
                      1'($urandom_range(1)));
         end else begin
            if (sb.state == S_ACK_SAMPLE) sda_bit = ($urandom_range(99) < nack_pct);
            else sda_bit = 1'($urandom_range(1));
            send_word(i2cee_pkg::CMD_TICK, 16'($urandom), 8'($urandom), sda_bit);
         end
      end
   endtask

   initial begin
      logic [7:0] dev_list[5];
      logic [7:0] limit_list[5];
      int         nack_list[5];
      int         target_list[5];

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= i2cee_pkg::CMD_TICK;
      req_mem_address <= '0;
      req_write_byte <= '0;
      req_sda_in <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= i2cee_pkg::CSR_DEVICE_ADDRESS;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle words and the unused command do nothing.
      send_word(i2cee_pkg::CMD_TICK, 16'hffff, 8'hff, 1'b1);
      send_word(i2cee_pkg::CMD_UNUSED, 16'h0000, 8'h00, 1'b0);
      send_word(i2cee_pkg::CMD_UNUSED, 16'hffff, 8'hff, 1'b1);
      stop_sending();

      // A retry limit of zero ends each request on its own word.
      apply_settings(8'hff, 8'h00);
      send_word(i2cee_pkg::CMD_WRITE, 16'hffff, 8'hff, 1'b1);
      send_word(i2cee_pkg::CMD_READ, 16'h0000, 8'h00, 1'b0);
      send_word(i2cee_pkg::CMD_WRITE, 16'h0000, 8'h00, 1'b0);
      send_word(i2cee_pkg::CMD_READ, 16'hffff, 8'hff, 1'b1);
      send_word(i2cee_pkg::CMD_TICK, 16'h5a5a, 8'ha5, 1'b0);
      stop_sending();

      dev_list = '{i2cee_pkg::DEVICE_ADDRESS_RESET, 8'h00, 8'hff, 8'($urandom),
                   8'($urandom)};
      limit_list = '{i2cee_pkg::RETRY_LIMIT_RESET, 8'd1, 8'd255, 8'd2, 8'($urandom)};
      nack_list = '{10, 30, 8, 15, 12};
      // Each phase finishes the transfer in progress, so the totals run past these.
      target_list = '{150, 150, 180, 180, 180};
      for (int p = 0; p < 5; p++) begin
         apply_settings(dev_list[p], limit_list[p]);
         nack_pct = nack_list[p];
         no_gaps = (p == 2);
         if (p == 3) hold_off_req = 1'b1;
         steps_taken = 0;
         while (steps_taken < target_list[p]) run_transfer();
         stop_sending();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
